[rtl/btmx_pkg.sv]
// Package for the binary trie maximum-xor unit.
// Holds command and status codes, sequencer states and the result type.
// No dependencies; used by btmx_core and binary_trie_max_xor_unit.
`timescale 1ns / 1ps

package btmx_pkg;

  localparam int KEY_W       = 31;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = 20;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - KEY_W - STATUS_W;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NO_ROOM = 2'd2,
    ST_ABSENT  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QRY,
    S_INS_CHK,
    S_INS_ROOM,
    S_INS_UPD,
    S_ERA_CHK,
    S_ERA_UPD,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] best_xor;
  } result_t;

endpackage

[rtl/btmx_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; instantiated by btmx_core for the link and count stores.
`timescale 1ns / 1ps

module btmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/btmx_core.sv]
// Trie sequencer: walks the node pool one level per cycle for query, insert and erase.
// Depends on btmx_pkg and instantiates btmx_ram for the link rows and path counts.
`timescale 1ns / 1ps

module btmx_core #(
  parameter int KEY_BITS   = 31,
  parameter int NODE_COUNT = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  btmx_pkg::cmd_t              start_cmd,
  input  logic [btmx_pkg::KEY_W-1:0]  start_key,
  output logic                        ready,
  input  logic                        res_ready,
  output logic                        res_valid,
  output btmx_pkg::result_t           res
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int DW = $clog2(KEY_BITS + 1);
  localparam int SW = IW + 2;
  localparam int CW = btmx_pkg::CNT_W;
  localparam logic [IW:0]   FREE_MAX = (IW + 1)'(NODE_COUNT);
  localparam logic [DW-1:0] LEAF_D   = DW'(KEY_BITS);
  localparam logic [DW-1:0] LAST_D   = DW'(KEY_BITS - 1);

  btmx_pkg::state_t  state_r, state_nxt;
  btmx_pkg::status_t status_r, status_nxt;

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [KEY_BITS-1:0] key_sh_r, key_sh_nxt;
  logic [KEY_BITS-1:0] acc_r, acc_nxt;
  logic [DW-1:0]       depth_r, depth_nxt;
  logic [DW-1:0]       need_r, need_nxt;
  logic [IW-1:0]       cur_r, cur_nxt;
  logic [IW-1:0]       par_r, par_nxt;
  logic [2*IW-1:0]     par_row_r, par_row_nxt;
  logic                par_kb_r, par_kb_nxt;
  logic [IW:0]         free_r, free_nxt;
  logic                alloc_r, alloc_nxt;
  logic [2*IW-1:0]     root_r, root_nxt;

  logic [2*IW-1:0] lnk_rdata, lnk_wdata, row_now, row_cut;
  logic [IW-1:0]   lnk_waddr, cnt_waddr;
  logic            lnk_we, cnt_we;
  logic [CW-1:0]   cnt_rdata, cnt_wdata, cnt_inc, cnt_dec;
  logic            kb, at_leaf;
  logic [IW-1:0]   lk, lo;

  // Place a link value in the slot chosen by the key bit, keeping the other slot.
  function automatic logic [2*IW-1:0] set_row(input logic [2*IW-1:0] row, input logic sel,
                                              input logic [IW-1:0] val);
    logic [2*IW-1:0] r;
    r = row;
    if (sel) begin
      r[2*IW-1:IW] = val;
    end else begin
      r[IW-1:0] = val;
    end
    return r;
  endfunction

  btmx_ram #(.WIDTH(2 * IW), .DEPTH(NODE_COUNT)) u_links (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (cur_nxt),
    .rdata (lnk_rdata)
  );

  btmx_ram #(.WIDTH(CW), .DEPTH(NODE_COUNT)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cur_nxt),
    .rdata (cnt_rdata)
  );

  // The root row lives in flops; a node created in this pass has no children yet.
  assign row_now = alloc_r ? '0 : ((cur_r == '0) ? root_r : lnk_rdata);
  assign kb      = key_sh_r[KEY_BITS-1];
  assign lk      = kb ? row_now[2*IW-1:IW] : row_now[IW-1:0];
  assign lo      = kb ? row_now[IW-1:0] : row_now[2*IW-1:IW];
  assign at_leaf = (depth_r == LEAF_D);
  assign cnt_inc = cnt_rdata + CW'(1);
  assign cnt_dec = (cnt_rdata != '0) ? cnt_rdata - CW'(1) : cnt_rdata;
  assign row_cut = set_row(par_row_r, par_kb_r, '0);

  assign ready        = (state_r == btmx_pkg::S_IDLE);
  assign res.status   = status_r;
  assign res.best_xor = btmx_pkg::KEY_W'(acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btmx_pkg::S_IDLE;
      free_r  <= (IW + 1)'(1);
      root_r  <= '0;
      alloc_r <= 1'b0;
      depth_r <= '0;
      cur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      root_r  <= root_nxt;
      alloc_r <= alloc_nxt;
      depth_r <= depth_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    key_r     <= key_nxt;
    key_sh_r  <= key_sh_nxt;
    acc_r     <= acc_nxt;
    need_r    <= need_nxt;
    par_r     <= par_nxt;
    par_row_r <= par_row_nxt;
    par_kb_r  <= par_kb_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    status_nxt  = status_r;
    key_nxt     = key_r;
    key_sh_nxt  = key_sh_r;
    acc_nxt     = acc_r;
    depth_nxt   = depth_r;
    need_nxt    = need_r;
    cur_nxt     = cur_r;
    par_nxt     = par_r;
    par_row_nxt = par_row_r;
    par_kb_nxt  = par_kb_r;
    free_nxt    = free_r;
    alloc_nxt   = alloc_r;
    root_nxt    = root_r;
    lnk_we      = 1'b0;
    lnk_waddr   = cur_r;
    lnk_wdata   = set_row(row_now, kb, free_r[IW-1:0]);
    cnt_we      = 1'b0;
    cnt_waddr   = cur_r;
    cnt_wdata   = cnt_inc;
    res_valid   = 1'b0;

    case (state_r)
      btmx_pkg::S_IDLE: begin
        if (start) begin
          key_nxt    = KEY_BITS'(start_key);
          key_sh_nxt = KEY_BITS'(start_key);
          cur_nxt    = '0;
          depth_nxt  = '0;
          acc_nxt    = '0;
          alloc_nxt  = 1'b0;
          status_nxt = btmx_pkg::ST_OK;
          case (start_cmd)
            btmx_pkg::CMD_INSERT: state_nxt = btmx_pkg::S_INS_CHK;
            btmx_pkg::CMD_ERASE:  state_nxt = btmx_pkg::S_ERA_CHK;
            btmx_pkg::CMD_QUERY:  state_nxt = btmx_pkg::S_QRY;
            default:              state_nxt = btmx_pkg::S_DONE;
          endcase
        end
      end

      btmx_pkg::S_QRY: begin
        if (depth_r == '0 && root_r == '0) begin
          status_nxt = btmx_pkg::ST_EMPTY;
          state_nxt  = btmx_pkg::S_DONE;
        end else begin
          cur_nxt    = (lo != '0) ? lo : lk;
          acc_nxt    = (acc_r << 1) | KEY_BITS'(lo != '0);
          depth_nxt  = depth_r + DW'(1);
          key_sh_nxt = key_sh_r << 1;
          if (depth_r == LAST_D) begin
            state_nxt = btmx_pkg::S_DONE;
          end
        end
      end

      btmx_pkg::S_INS_CHK: begin
        if (depth_r != '0 && cnt_rdata >= btmx_pkg::CNT_MAX) begin
          status_nxt = btmx_pkg::ST_NO_ROOM;
          state_nxt  = btmx_pkg::S_DONE;
        end else if (at_leaf) begin
          need_nxt  = '0;
          state_nxt = btmx_pkg::S_INS_ROOM;
        end else if (lk == '0) begin
          // Every level from here down needs a fresh node.
          need_nxt  = LEAF_D - depth_r;
          state_nxt = btmx_pkg::S_INS_ROOM;
        end else begin
          cur_nxt    = lk;
          depth_nxt  = depth_r + DW'(1);
          key_sh_nxt = key_sh_r << 1;
        end
      end

      btmx_pkg::S_INS_ROOM: begin
        if (SW'(free_r) + SW'(need_r) > SW'(NODE_COUNT)) begin
          status_nxt = btmx_pkg::ST_NO_ROOM;
          state_nxt  = btmx_pkg::S_DONE;
        end else begin
          cur_nxt    = '0;
          depth_nxt  = '0;
          key_sh_nxt = key_r;
          alloc_nxt  = 1'b0;
          state_nxt  = btmx_pkg::S_INS_UPD;
        end
      end

      btmx_pkg::S_INS_UPD: begin
        if (depth_r != '0) begin
          cnt_we    = 1'b1;
          cnt_wdata = alloc_r ? CW'(1) : cnt_inc;
        end
        if (at_leaf) begin
          if (alloc_r) begin
            lnk_we    = 1'b1;
            lnk_wdata = '0;
          end
          state_nxt = btmx_pkg::S_DONE;
        end else if (alloc_r || lk == '0) begin
          if (cur_r == '0 && !alloc_r) begin
            root_nxt = set_row(row_now, kb, free_r[IW-1:0]);
          end else begin
            lnk_we = 1'b1;
          end
          cur_nxt    = free_r[IW-1:0];
          free_nxt   = free_r + (IW + 1)'(1);
          alloc_nxt  = 1'b1;
          depth_nxt  = depth_r + DW'(1);
          key_sh_nxt = key_sh_r << 1;
        end else begin
          cur_nxt    = lk;
          depth_nxt  = depth_r + DW'(1);
          key_sh_nxt = key_sh_r << 1;
        end
      end

      btmx_pkg::S_ERA_CHK: begin
        if (at_leaf) begin
          cur_nxt    = '0;
          depth_nxt  = '0;
          key_sh_nxt = key_r;
          state_nxt  = btmx_pkg::S_ERA_UPD;
        end else if (lk == '0) begin
          status_nxt = btmx_pkg::ST_ABSENT;
          state_nxt  = btmx_pkg::S_DONE;
        end else begin
          cur_nxt    = lk;
          depth_nxt  = depth_r + DW'(1);
          key_sh_nxt = key_sh_r << 1;
        end
      end

      btmx_pkg::S_ERA_UPD: begin
        if (depth_r != '0) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_dec;
          // A node whose count drops to zero is cut from its parent.
          if (cnt_dec == '0) begin
            if (par_r == '0) begin
              root_nxt = row_cut;
            end else begin
              lnk_we    = 1'b1;
              lnk_waddr = par_r;
              lnk_wdata = row_cut;
            end
          end
        end
        if (at_leaf) begin
          state_nxt = btmx_pkg::S_DONE;
        end else begin
          par_nxt     = cur_r;
          par_row_nxt = row_now;
          par_kb_nxt  = kb;
          cur_nxt     = lk;
          depth_nxt   = depth_r + DW'(1);
          key_sh_nxt  = key_sh_r << 1;
        end
      end

      btmx_pkg::S_DONE: begin
        res_valid = res_ready;
        if (res_ready) begin
          state_nxt = btmx_pkg::S_IDLE;
        end
      end

      default: state_nxt = btmx_pkg::S_IDLE;
    endcase
  end

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FREE_MAX)
    else $error("free node pointer ran past the pool");

  a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == btmx_pkg::S_INS_UPD && !at_leaf && (alloc_r || lk == '0))
      |-> (free_r < FREE_MAX))
    else $error("node allocated with the pool exhausted");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= LEAF_D)
    else $error("walk went below the leaf level");

  a_root_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_we |-> (cnt_waddr != '0))
    else $error("count write aimed at the root");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (state_r == btmx_pkg::S_IDLE))
    else $error("sequencer did not return to idle after a result");

endmodule

[rtl/binary_trie_max_xor_unit.sv]
// Top level of the binary trie maximum-xor unit: stream ports and result register.
// Depends on btmx_pkg and btmx_core (which holds the node pool memories).
//
//   channel | ports                     | item fields (lowest bit first)
//   --------+---------------------------+----------------------------------------
//   input   | in_tvalid/tready/tdata/tuser | tdata: key[30:0]; tuser: command[1:0]
//   result  | out_tvalid/tready/tdata   | tdata: best_xor[30:0], status[32:31]
//
// Query walks the trie once from accept to result; insert walks it twice, with a room
// check between the walks, and erase walks it twice; a walk may stop early.
// The walk is paced by the link memory read loop: one trie level per cycle.
// Reset needs no clearing pass: root links sit in flops, other rows are written on allocation.
// While an item is in work in_tready is low; a result waits in the output register
// and the next item is accepted meanwhile.
`timescale 1ns / 1ps

module binary_trie_max_xor_unit #(
  parameter int KEY_BITS   = 31,
  parameter int NODE_COUNT = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [btmx_pkg::IN_TDATA_W-1:0]     in_tdata,   // key[30:0], zero pad
  input  logic [btmx_pkg::CMD_W-1:0]          in_tuser,   // command[1:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [btmx_pkg::OUT_TDATA_W-1:0]    out_tdata   // best_xor[30:0], status[32:31], pad
);

  logic              core_ready, res_valid, res_ready;
  btmx_pkg::result_t res;
  logic              out_valid_r, out_valid_nxt;
  logic [btmx_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  btmx_core #(.KEY_BITS(KEY_BITS), .NODE_COUNT(NODE_COUNT)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid && core_ready),
    .start_cmd (btmx_pkg::cmd_t'(in_tuser)),
    .start_key (in_tdata[btmx_pkg::KEY_W-1:0]),
    .ready     (core_ready),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  assign in_tready  = core_ready;
  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{btmx_pkg::OUT_PAD_W{1'b0}}, res.status, res.best_xor};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
